[rtl/core/knps_pkg.sv]
package knps_pkg;

  // Stored squared distance width, fixed by the store layout.
  localparam int unsigned DIST_BITS = 52;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // Width of the max_targets register.
  localparam int unsigned KREG_BITS = 5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAX_TARGETS = 2'd0,
    CFG_ORIGIN_X    = 2'd1,
    CFG_ORIGIN_Y    = 2'd2,
    CFG_ORIGIN_Z    = 2'd3
  } cfg_idx_e;

  // Coordinate axis handled by the distance unit in a given cycle.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;    // latch the incoming point
    logic  mag_en;     // take |point - origin| on the selected axis
    axis_e axis;
    logic  sq_en;      // square the magnitude
    logic  acc_clr;    // clear the distance accumulator
    logic  acc_en;     // add the square into the accumulator
    logic  wr_en;      // write distance and id into the stores
    logic  sel_start;  // open a selection: forget the previous pick
    logic  rd_en;      // read the stores at the read address
    logic  take_all;   // load-order mode: every read entry is the pick
    logic  emit;       // load the best entry into the output register
    logic  run_last;   // the emitted id closes the set
    logic  ovf;        // points of this set were dropped
  } knps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
  } knps_sts_t;

endpackage

[rtl/core/knps_dpath.sv]
module knps_dpath #(
  parameter int unsigned POINT_CAPACITY = 64,
  parameter int unsigned COORD_BITS     = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  knps_pkg::cfg_idx_e                cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic [15:0]                       point_id_i,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  input  knps_pkg::knps_cmd_t               cmd_i,
  input  logic [$clog2(POINT_CAPACITY)-1:0] wr_addr_i,
  input  logic [$clog2(POINT_CAPACITY)-1:0] rd_addr_i,
  output knps_pkg::knps_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       chosen_id_o,
  output logic                              run_last_o,
  output logic                              overflowed_o
);
  import knps_pkg::*;

  localparam int unsigned AW = $clog2(POINT_CAPACITY);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned EW = (SW > DIST_BITS) ? SW : DIST_BITS + 1;

  logic signed [CB-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [CB-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic [15:0]          pt_id_q;

  logic signed [CB-1:0] sel_pt, sel_org;
  logic signed [CB:0]   diff_w, diff_neg_w;
  logic [CB-1:0]        mag_w, mag_q;
  logic [2*CB-1:0]      sq_w, sq_q;
  logic [SW-1:0]        acc_q;
  logic [EW-1:0]        acc_ext;
  logic [DIST_BITS-1:0] dist_w;

  logic [DIST_BITS-1:0] dist_mem [POINT_CAPACITY];
  logic [15:0]          id_mem   [POINT_CAPACITY];
  logic [DIST_BITS-1:0] rd_dist_q;
  logic [15:0]          rd_id_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 cmp_valid_q;

  logic [DIST_BITS-1:0] best_d_q, last_d_q;
  logic [AW-1:0]        best_idx_q, last_idx_q;
  logic [15:0]          best_id_q;
  logic                 best_found_q, has_last_q;
  logic                 eligible_w, take_w;

  logic                 out_valid_q, run_last_q, ovf_q;
  logic [15:0]          chosen_id_q;

  // Origin registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pt_id_q <= point_id_i;
      pt_x_q  <= point_x_i;
      pt_y_q  <= point_y_i;
      pt_z_q  <= point_z_i;
    end
  end

  // Distance unit: abs difference, square, accumulate; one axis per cycle.
  always_comb begin
    unique case (cmd_i.axis)
      AXIS_X: begin
        sel_pt  = pt_x_q;
        sel_org = origin_x_q;
      end
      AXIS_Y: begin
        sel_pt  = pt_y_q;
        sel_org = origin_y_q;
      end
      AXIS_Z: begin
        sel_pt  = pt_z_q;
        sel_org = origin_z_q;
      end
      default: begin
        sel_pt  = pt_x_q;
        sel_org = origin_x_q;
      end
    endcase
  end

  assign diff_w     = {sel_pt[CB-1], sel_pt} - {sel_org[CB-1], sel_org};
  assign diff_neg_w = -diff_w;
  assign mag_w      = diff_w[CB] ? diff_neg_w[CB-1:0] : diff_w[CB-1:0];
  assign sq_w       = {{CB{1'b0}}, mag_q} * {{CB{1'b0}}, mag_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_en) mag_q <= mag_w;
    if (cmd_i.sq_en)  sq_q  <= sq_w;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + SW'(sq_q);
    end
  end

  // Saturate the sum at the stored width.
  assign acc_ext = EW'(acc_q);
  assign dist_w  = (acc_ext > EW'(DIST_MAX)) ? DIST_MAX : acc_ext[DIST_BITS-1:0];

  // Point stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      dist_mem[wr_addr_i] <= dist_w;
      id_mem[wr_addr_i]   <= pt_id_q;
    end
    if (cmd_i.rd_en) begin
      rd_dist_q <= dist_mem[rd_addr_i];
      rd_id_q   <= id_mem[rd_addr_i];
      rd_idx_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cmp_valid_q <= 1'b0;
    else         cmp_valid_q <= cmd_i.rd_en;
  end

  // An entry is a candidate if it orders after the previous pick by
  // (distance, index); among candidates the smallest distance wins, and
  // the strict compare keeps the earlier index on a tie.
  assign eligible_w = !has_last_q || (rd_dist_q > last_d_q) ||
                      ((rd_dist_q == last_d_q) && (rd_idx_q > last_idx_q));
  assign take_w = cmp_valid_q &&
                  (cmd_i.take_all ||
                   (eligible_w && (!best_found_q || (rd_dist_q < best_d_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      has_last_q   <= 1'b0;
    end else if (cmd_i.sel_start) begin
      best_found_q <= 1'b0;
      has_last_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      best_found_q <= 1'b0;
      has_last_q   <= 1'b1;
    end else if (take_w) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_w) begin
      best_d_q   <= rd_dist_q;
      best_idx_q <= rd_idx_q;
      best_id_q  <= rd_id_q;
    end
    if (cmd_i.emit) begin
      last_d_q   <= best_d_q;
      last_idx_q <= best_idx_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      chosen_id_q <= best_id_q;
      run_last_q  <= cmd_i.run_last;
      ovf_q       <= cmd_i.ovf;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign chosen_id_o    = chosen_id_q;
  assign run_last_o     = run_last_q;
  assign overflowed_o   = ovf_q;

endmodule

[rtl/core/knps_ctrl.sv]
module knps_ctrl #(
  parameter int unsigned POINT_CAPACITY = 64,
  parameter int unsigned K_LIMIT        = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  knps_pkg::cfg_idx_e                cfg_index_i,
  input  logic [knps_pkg::KREG_BITS-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              set_end_i,
  input  knps_pkg::knps_sts_t               sts_i,
  output knps_pkg::knps_cmd_t               cmd_o,
  output logic [$clog2(POINT_CAPACITY)-1:0] wr_addr_o,
  output logic [$clog2(POINT_CAPACITY)-1:0] rd_addr_o
);
  import knps_pkg::*;

  localparam int unsigned AW = $clog2(POINT_CAPACITY);
  localparam int unsigned CW = $clog2(POINT_CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CALC  = 7'b0000010,
    ST_STORE = 7'b0000100,
    ST_SETUP = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           step_q, step_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 drop_q, drop_d;
  logic                 set_end_q, set_end_d;
  logic [AW-1:0]        scan_q, scan_d;
  logic [PW-1:0]        pick_q, pick_d;
  logic [PW-1:0]        picks_q, picks_d;
  logic                 mode_all_q, mode_all_d;
  logic [KREG_BITS-1:0] max_targets_q;

  logic [PW-1:0]        k_eff_w, n_ext_w, picks_w;
  logic                 mode_all_w, last_pick_w, scan_end_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_targets_q <= KREG_BITS'(1);
    end else if (cfg_we_i && (cfg_index_i == CFG_MAX_TARGETS)) begin
      max_targets_q <= cfg_data_i;
    end
  end

  assign k_eff_w    = (int'(max_targets_q) > K_LIMIT) ? PW'(K_LIMIT) : PW'(max_targets_q);
  assign n_ext_w    = PW'(count_q);
  assign mode_all_w = (n_ext_w <= k_eff_w);
  assign picks_w    = mode_all_w ? n_ext_w : k_eff_w;

  assign last_pick_w = (pick_q == picks_q - PW'(1));
  assign scan_end_w  = mode_all_q || (CW'(scan_q) == count_q - CW'(1));

  assign wr_addr_o = count_q[AW-1:0];
  assign rd_addr_o = mode_all_q ? pick_q[AW-1:0] : scan_q;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    count_d    = count_q;
    drop_d     = drop_q;
    set_end_d  = set_end_q;
    scan_d     = scan_q;
    pick_d     = pick_q;
    picks_d    = picks_q;
    mode_all_d = mode_all_q;

    cmd_o          = '0;
    cmd_o.axis     = axis_e'(step_q[1:0]);
    cmd_o.take_all = mode_all_q;
    cmd_o.run_last = last_pick_w;
    cmd_o.ovf      = drop_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          set_end_d     = set_end_i;
          if (count_q == CW'(POINT_CAPACITY)) begin
            // Store full: drop the point, still honor its set end.
            drop_d  = 1'b1;
            state_d = set_end_i ? ST_SETUP : ST_IDLE;
          end else begin
            step_d  = '0;
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd_o.mag_en  = (step_q <= 3'd2);
        cmd_o.sq_en   = (step_q >= 3'd1) && (step_q <= 3'd3);
        cmd_o.acc_clr = (step_q == 3'd0);
        cmd_o.acc_en  = (step_q >= 3'd2);
        if (step_q == 3'd4) begin
          state_d = ST_STORE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_STORE: begin
        cmd_o.wr_en = 1'b1;
        count_d     = count_q + CW'(1);
        state_d     = set_end_q ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        cmd_o.sel_start = 1'b1;
        mode_all_d      = mode_all_w;
        picks_d         = picks_w;
        pick_d          = '0;
        scan_d          = '0;
        if (picks_w == '0) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (scan_end_w) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last_pick_w) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            pick_d  = pick_q + PW'(1);
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      count_q    <= '0;
      drop_q     <= 1'b0;
      set_end_q  <= 1'b0;
      scan_q     <= '0;
      pick_q     <= '0;
      picks_q    <= '0;
      mode_all_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      set_end_q  <= set_end_d;
      scan_q     <= scan_d;
      pick_q     <= pick_d;
      picks_q    <= picks_d;
      mode_all_q <= mode_all_d;
    end
  end

endmodule

[rtl/core/k_nearest_point_select_core.sv]
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ------------------------------------------
// point     in         in_valid_i / in_ready_o point_id_i, point_x/y/z_i, set_end_i
// result    out        out_valid_o/out_ready_i chosen_id_o, run_last_o, overflowed_o
// config    in         cfg_we_i (no wait)      cfg_index_i, cfg_data_i
//
// Loading a point runs the transfer, five distance steps (one axis a cycle through one
// shared multiplier) and a store write; a dropped point takes only the transfer.
// On set_end: a setup step, then per id, when n > k, one store read per entry, a compare
// drain and the emit, or, when all n come in load order, one read, the drain and the emit.
// Reset is asynchronous and clears control and configuration, not the point stores.
// A stalled result waits in the output register and holds the controller before the emit.
module k_nearest_point_select_core #(
  parameter int unsigned POINT_CAPACITY = 64,
  parameter int unsigned K_LIMIT        = 16,
  parameter int unsigned COORD_BITS     = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [((COORD_BITS > knps_pkg::KREG_BITS) ? COORD_BITS : knps_pkg::KREG_BITS)-1:0]
                                       cfg_data_i,
  // point channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [15:0]                  point_id_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         set_end_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  chosen_id_o,
  output logic                         run_last_o,
  output logic                         overflowed_o
);
  import knps_pkg::*;

  localparam int unsigned AW = $clog2(POINT_CAPACITY);

  knps_cmd_t          cmd;
  knps_sts_t          sts;
  cfg_idx_e           cfg_idx;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  assign cfg_idx = cfg_idx_e'(cfg_index_i);

  // Sequencer: load, distance steps, store, selection scans and emits.
  knps_ctrl #(
    .POINT_CAPACITY(POINT_CAPACITY),
    .K_LIMIT       (K_LIMIT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_idx),
    .cfg_data_i (cfg_data_i[KREG_BITS-1:0]),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .set_end_i  (set_end_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  // Distance unit, point stores, min search and output register.
  knps_dpath #(
    .POINT_CAPACITY(POINT_CAPACITY),
    .COORD_BITS    (COORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data_i[COORD_BITS-1:0]),
    .point_id_i  (point_id_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .chosen_id_o (chosen_id_o),
    .run_last_o  (run_last_o),
    .overflowed_o(overflowed_o)
  );

endmodule

[test/tb_k_nearest_point_select_core.sv]
`timescale 1ns / 100ps

module tb_k_nearest_point_select_core;
  import knps_pkg::*;

  localparam int POINT_CAP    = 64;
  localparam int K_LIMIT      = 16;
  localparam int COORD_W      = 24;
  // Margin for the worst selection, with k = 16 and n = 64.
  localparam int DRAIN_CYCLES = 1200;
  localparam int SETTLE_LIMIT = 200000;
  localparam int HOLD_CYCLES  = 600;
  localparam int TOTAL_POINTS = 260;
  localparam int IDLE_PCT     = 11;

  typedef struct packed {
    logic [15:0]        id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               set_end;
  } point_t;

  typedef struct packed {
    logic [15:0] id;
    logic        last;
    logic        ovf;
  } pick_t;

  typedef enum logic {
    ROW_CFG,
    ROW_POINT
  } row_kind_e;

  // One line of the directed stimulus. n_typed < 0 means the predictor
  // supplies the expected picks; otherwise the ids are given in the row.
  typedef struct {
    row_kind_e          kind;
    cfg_idx_e           reg_idx;
    logic [COORD_W-1:0] reg_val;
    point_t             pt;
    int                 n_typed;
    logic [2:0][15:0]   typed_ids;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [15:0]        point_id_i  = '0;
  logic [COORD_W-1:0] point_x_i   = '0;
  logic [COORD_W-1:0] point_y_i   = '0;
  logic [COORD_W-1:0] point_z_i   = '0;
  logic               set_end_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        chosen_id_o;
  logic               run_last_o;
  logic               overflowed_o;

  // Predictor copy of the configuration and of the point store.
  logic [KREG_BITS-1:0] k_reg;
  logic [COORD_W-1:0]   org_x, org_y, org_z;
  logic [DIST_BITS-1:0] stored_dist [POINT_CAP];
  logic [15:0]          stored_id   [POINT_CAP];
  int                   stored_cnt;
  bit                   dropped;

  pick_t     expected_picks [$];
  stim_row_t directed_rows  [$];

  bit no_idle          = 1'b0;
  bit hold_req         = 1'b0;
  bit points_in_flight = 1'b0;

  int mismatches    = 0;
  int points_sent   = 0;
  int sets_closed   = 0;
  int overflow_sets = 0;
  int picks_checked = 0;
  int reg_writes    = 0;

  k_nearest_point_select_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_id_i   (point_id_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .set_end_i    (set_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .chosen_id_o  (chosen_id_o),
    .run_last_o   (run_last_o),
    .overflowed_o (overflowed_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_mismatch(string msg);
    $display("[%0t] pick mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Store one point; on set_end, work out the ids the block must report and
  // clear the set. Picks go to the expectation queue only when keep is set.
  function automatic void select_nearest(point_t p, bit keep);
    longint               dx, dy, dz;
    logic [63:0]          d;
    int                   k_eff;
    int                   best;
    bit                   found;
    bit                   taken [POINT_CAP];
    pick_t                pk;

    if (stored_cnt < POINT_CAP) begin
      dx = $signed(p.x) - $signed(org_x);
      dy = $signed(p.y) - $signed(org_y);
      dz = $signed(p.z) - $signed(org_z);
      d  = dx * dx + dy * dy + dz * dz;
      // Saturate at all ones; out of reach with 24-bit coordinates.
      stored_dist[stored_cnt] = (d > DIST_MAX) ? DIST_MAX : d[DIST_BITS-1:0];
      stored_id[stored_cnt]   = p.id;
      stored_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.set_end) return;

    sets_closed++;
    if (dropped) overflow_sets++;
    k_eff  = (k_reg > K_LIMIT) ? K_LIMIT : k_reg;
    pk.ovf = dropped;
    if (stored_cnt <= k_eff) begin
      // Small set: every id in load order.
      for (int i = 0; i < stored_cnt; i++) begin
        pk.id   = stored_id[i];
        pk.last = (i == stored_cnt - 1);
        if (keep) expected_picks.push_back(pk);
      end
    end else begin
      foreach (taken[i]) taken[i] = 1'b0;
      for (int j = 0; j < k_eff; j++) begin
        best  = 0;
        found = 1'b0;
        // Strict compare keeps the earlier point on a tie.
        for (int i = 0; i < stored_cnt; i++) begin
          if (!taken[i] && (!found || stored_dist[i] < stored_dist[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        taken[best] = 1'b1;
        pk.id       = stored_id[best];
        pk.last     = (j == k_eff - 1);
        if (keep) expected_picks.push_back(pk);
      end
    end
    stored_cnt = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [COORD_W-1:0] val);
    stim_row_t r;
    r.kind      = ROW_CFG;
    r.reg_idx   = idx;
    r.reg_val   = val;
    r.pt        = '0;
    r.n_typed   = -1;
    r.typed_ids = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pt(logic [15:0] id, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                 logic set_end, int n_typed, logic [15:0] id0 = '0,
                                 logic [15:0] id1 = '0, logic [15:0] id2 = '0);
    stim_row_t r;
    r.kind         = ROW_POINT;
    r.reg_idx      = CFG_MAX_TARGETS;
    r.reg_val      = '0;
    r.pt           = '{id: id, x: x, y: y, z: z, set_end: set_end};
    r.n_typed      = n_typed;
    r.typed_ids[0] = id0;
    r.typed_ids[1] = id1;
    r.typed_ids[2] = id2;
    directed_rows.push_back(r);
  endfunction

  // Drop valid, wait for every expected pick, then let the block finish any
  // selection that reports nothing.
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (expected_picks.size() != 0 && guard < SETTLE_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    points_in_flight = 1'b0;
  endtask

  // Write one register at the next edge. The enable stays high for a
  // following write and is dropped by the next point or idle wait.
  task automatic write_reg(cfg_idx_e idx, logic [COORD_W-1:0] val);
    if (points_in_flight) wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_MAX_TARGETS: k_reg = val[KREG_BITS-1:0];
      CFG_ORIGIN_X:    org_x = val;
      CFG_ORIGIN_Y:    org_y = val;
      CFG_ORIGIN_Z:    org_z = val;
      default: ;
    endcase
  endtask

  // Offer one point and hold it until the transfer completes.
  task automatic offer_point(point_t p);
    cfg_we_i <= 1'b0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_id_i <= p.id;
    point_x_i  <= p.x;
    point_y_i  <= p.y;
    point_z_i  <= p.z;
    set_end_i  <= p.set_end;
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
    points_in_flight = 1'b1;
  endtask

  // Half full-range values, some right next to the origin so that
  // distances tie, and some at the coordinate extremes.
  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] org);
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode < 5) return COORD_W'($urandom);
    if (mode < 8) return org + COORD_W'($urandom_range(6)) - COORD_W'(3);
    if (mode == 8) return {1'b0, {(COORD_W-1){1'b1}}};
    return {1'b1, {(COORD_W-1){1'b0}}};
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    return $urandom_range(1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
  endfunction

  // Result side: check each transfer against the oldest expectation, then
  // choose ready for the next cycle. A hold request parks ready low for a
  // long stretch so the block fills up and back-pressures its input.
  initial begin : pick_sink
    pick_t want;
    int    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_picks.size() == 0) begin
          flag_mismatch($sformatf("unexpected id %h last %b ovf %b",
                                  chosen_id_o, run_last_o, overflowed_o));
        end else begin
          want = expected_picks.pop_front();
          picks_checked++;
          if (chosen_id_o !== want.id || run_last_o !== want.last ||
              overflowed_o !== want.ovf) begin
            flag_mismatch($sformatf("id %h/%h last %b/%b ovf %b/%b (got/want)",
                                    chosen_id_o, want.id, run_last_o, want.last,
                                    overflowed_o, want.ovf));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    point_t             p;
    pick_t              pk;
    logic [15:0]        last_id;
    logic [COORD_W-1:0] kval;
    int                 ph, n_sets, set_len, k_eff;

    // Reset values of the registers.
    k_reg      = KREG_BITS'(1);
    org_x      = '0;
    org_y      = '0;
    org_z      = '0;
    stored_cnt = 0;
    dropped    = 1'b0;
    last_id    = '0;

    // Directed rows, starting from the reset configuration (k = 1, origin 0).
    add_pt(16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1, 16'h0000);
    add_pt(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1, 16'hFFFF);
    // Opposite corners: the positive one is nearer by a hair.
    add_pt(16'h0001, 24'h800000, 24'h800000, 24'h800000, 1'b0, -1);
    add_pt(16'h0002, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, -1);
    // Equal distance: the earlier point wins.
    add_pt(16'h000A, 24'h000003, 24'h000000, 24'h000000, 1'b0, -1);
    add_pt(16'h000B, 24'h000000, 24'hFFFFFD, 24'h000000, 1'b1, 1, 16'h000A);
    // k of zero reports nothing but still clears the set.
    add_cfg(CFG_MAX_TARGETS, 24'h000000);
    add_pt(16'h1234, 24'h000005, 24'h000005, 24'h000005, 1'b0, -1);
    add_pt(16'h4321, 24'h000001, 24'h000001, 24'h000001, 1'b1, 0);
    // All-ones data: only the low bits land, and 31 saturates to the limit.
    add_cfg(CFG_MAX_TARGETS, 24'hFFFFFF);
    add_cfg(CFG_ORIGIN_X, 24'h7FFFFF);
    add_cfg(CFG_ORIGIN_Y, 24'h800000);
    add_cfg(CFG_ORIGIN_Z, 24'h7FFFFF);
    // Three points under k = 16: load order, repeated ids each reported.
    add_pt(16'h0007, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, -1);
    add_pt(16'h0007, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, -1);
    add_pt(16'h0005, 24'h000000, 24'h000000, 24'h000000, 1'b1, 3,
           16'h0007, 16'h0007, 16'h0005);
    add_cfg(CFG_MAX_TARGETS, 24'h000002);
    add_cfg(CFG_ORIGIN_X, 24'h000000);
    add_cfg(CFG_ORIGIN_Y, 24'h000000);
    add_cfg(CFG_ORIGIN_Z, 24'h000000);
    add_pt(16'h0100, 24'h00000A, 24'h000000, 24'h000000, 1'b0, -1);
    add_pt(16'h0200, 24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, -1);
    add_pt(16'h0300, 24'h000000, 24'h000000, 24'hFFFFF6, 1'b0, -1);
    add_pt(16'h0400, 24'h000000, 24'h000002, 24'h000000, 1'b1, -1);

    // Hold reset, then release it on an edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed rows.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        offer_point(directed_rows[r].pt);
        select_nearest(directed_rows[r].pt, directed_rows[r].n_typed < 0);
        for (int t = 0; t < directed_rows[r].n_typed; t++) begin
          pk.id   = directed_rows[r].typed_ids[t];
          pk.last = (t == directed_rows[r].n_typed - 1);
          pk.ovf  = 1'b0;
          expected_picks.push_back(pk);
        end
      end
    end

    // Random phases: reprogram k and the origin while idle, then stream sets.
    ph = 0;
    while (points_sent < TOTAL_POINTS) begin
      case (ph % 6)
        0:       kval = 24'd1;
        1:       kval = 24'd16;
        2:       kval = 24'($urandom_range(2, 15));
        3:       kval = 24'hFFFFFF;
        4:       kval = 24'd0;
        default: kval = 24'($urandom);
      endcase
      write_reg(CFG_MAX_TARGETS, kval);
      case (ph % 3)
        0: begin
          write_reg(CFG_ORIGIN_X, 24'($urandom));
          write_reg(CFG_ORIGIN_Y, 24'($urandom));
          write_reg(CFG_ORIGIN_Z, 24'($urandom));
        end
        1: begin
          write_reg(CFG_ORIGIN_X, pick_extreme());
          write_reg(CFG_ORIGIN_Y, pick_extreme());
          write_reg(CFG_ORIGIN_Z, pick_extreme());
        end
        default: begin
          write_reg(CFG_ORIGIN_X, 24'd0);
          write_reg(CFG_ORIGIN_Y, 24'd0);
          write_reg(CFG_ORIGIN_Z, 24'd0);
        end
      endcase
      k_eff   = (k_reg > K_LIMIT) ? K_LIMIT : k_reg;
      no_idle = (ph == 2);
      // Park the receiver while this phase keeps offering points.
      if (ph == 3) hold_req = 1'b1;
      n_sets = (ph == 1) ? 2 : $urandom_range(2, 4);
      for (int s = 0; s < n_sets; s++) begin
        // Phase 1 fills the store exactly, then overruns it so the closing
        // point itself is dropped.
        if (ph == 1) set_len = (s == 0) ? POINT_CAP : POINT_CAP + 2;
        else if ($urandom_range(3) == 0) set_len = k_eff + $urandom_range(1);
        else set_len = $urandom_range(1, 20);
        if (set_len < 1) set_len = 1;
        for (int i = 0; i < set_len; i++) begin
          p.id      = ($urandom_range(9) == 0) ? last_id : 16'($urandom);
          p.x       = pick_coord(org_x);
          p.y       = pick_coord(org_y);
          p.z       = pick_coord(org_z);
          p.set_end = (i == set_len - 1);
          offer_point(p);
          select_nearest(p, 1'b1);
          last_id = p.id;
        end
      end
      ph++;
    end
    no_idle = 1'b0;

    // Drain, then give any stray result time to show up.
    wait_idle();
    if (expected_picks.size() != 0) begin
      flag_mismatch($sformatf("%0d expected picks never arrived", expected_picks.size()));
    end

    $display("Covered %0d points in %0d sets (%0d overrun), %0d register writes.",
             points_sent, sets_closed, overflow_sets, reg_writes);
    $display("Checked %0d reported ids, %0d mismatches.", picks_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[k_nearest_point_select_core.f]
rtl/core/knps_pkg.sv
rtl/core/knps_dpath.sv
rtl/core/knps_ctrl.sv
rtl/core/k_nearest_point_select_core.sv
test/tb_k_nearest_point_select_core.sv
